// ===== hw/rtl/wsp_pkg.sv =====
// Shared types and constants for the wheel speed tachometer.
// No dependencies; imported by wsp_cfg, wsp_div and the top level.
package wsp_pkg;

	localparam int unsigned DIV_W   = 32;
	localparam int unsigned CFG_IDX_W = 3;

	// register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PPR      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_PER  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PER  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CIRC     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 3'd5;

	localparam logic [31:0] RPM_NUM = 32'd600000000;
	localparam logic [19:0] RPM_MAX = 20'd1000000;
	localparam logic [15:0] KMH_MAX = 16'd65535;
	localparam logic [10:0] MS_MAX  = 11'd2047;

	localparam logic EV_SPEED = 1'b0;
	localparam logic EV_STOP  = 1'b1;
	localparam logic KIND_EDGE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// effective configuration as seen by the datapath
	typedef struct packed {
		logic [31:0] modulus;   // clamped to at least 2
		logic [3:0]  ppr;       // clamped to at least 1
		logic [31:0] min_per;
		logic [31:0] max_per;
		logic [21:0] circ_um;
		logic [10:0] timeout_ms;
	} cfg_t;

endpackage

// ===== hw/rtl/wsp_cfg.sv =====
// Configuration register file for the tachometer.
// Depends on wsp_pkg; presents the register set, with modulus and ppr clamped, as a cfg_t.
module wsp_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [wsp_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [31:0]                   wr_data,
	output wsp_pkg::cfg_t                 cfg
);
	import wsp_pkg::*;

	logic [31:0] modulus_q;
	logic [3:0]  ppr_q;
	logic [31:0] min_per_q;
	logic [31:0] max_per_q;
	logic [21:0] circ_q;
	logic [10:0] timeout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= 32'd1000000;
			ppr_q     <= 4'd4;
			min_per_q <= 32'd7500;
			max_per_q <= 32'd100000;
			circ_q    <= 22'd157080;
			timeout_q <= 11'd500;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_MODULUS: modulus_q <= wr_data;
				CFG_PPR:     ppr_q     <= wr_data[3:0];
				CFG_MIN_PER: min_per_q <= wr_data;
				CFG_MAX_PER: max_per_q <= wr_data;
				CFG_CIRC:    circ_q    <= wr_data[21:0];
				CFG_TIMEOUT: timeout_q <= wr_data[10:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.modulus    = (modulus_q < 32'd2) ? 32'd2 : modulus_q;
		cfg.ppr        = (ppr_q == 4'd0) ? 4'd1 : ppr_q;
		cfg.min_per    = min_per_q;
		cfg.max_per    = max_per_q;
		cfg.circ_um    = circ_q;
		cfg.timeout_ms = timeout_q;
	end

endmodule

// ===== hw/rtl/wsp_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on wsp_pkg for the operand width; gives quotient and remainder.
module wsp_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [wsp_pkg::DIV_W-1:0] dividend,
	input  logic [wsp_pkg::DIV_W-1:0] divisor,
	output logic                      done,
	output logic [wsp_pkg::DIV_W-1:0] quot,
	output logic [wsp_pkg::DIV_W-1:0] rem
);
	import wsp_pkg::*;

	localparam int unsigned CNT_W = $clog2(DIV_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DIV_W-1:0] q_q;
	logic [DIV_W-1:0] r_q;
	logic [DIV_W-1:0] d_q;
	logic [DIV_W:0]   trial;
	logic             ge;

	// shift the next dividend bit into the partial remainder
	assign trial = {r_q, q_q[DIV_W-1]};
	assign ge    = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CNT_W'(DIV_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			q_q <= {q_q[DIV_W-2:0], ge};
			r_q <= ge ? DIV_W'(trial - {1'b0, d_q}) : trial[DIV_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = q_q;
	assign rem  = r_q;

endmodule

// ===== hw/rtl/wheel_speed_from_pulse_captures.sv =====
// Wheel speed tachometer: measures revolution spans from edge timestamps and reports
// the span, RPM and km/h, or a single stopped beat after a tick timeout. Depends on
// wsp_pkg, wsp_cfg and wsp_div.
//
// One 32-step bit-serial divider is used in turn for the timestamp reduction, the
// stored start reduction, the RPM quotient and the km/h quotient: a sensor edge is
// reduced modulo the counter, and the edge that closes a revolution also reduces the
// stored start, then runs both quotients when its span gives a reading. s_tready is
// low while an edge is in work.
// A result waits in the output register while the next item is taken. Configuration
// writes are taken in any cycle (cfg_ready is always high) and must be done while idle.
module wheel_speed_from_pulse_captures #(
	parameter int unsigned TIME_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [31:0]                   s_tdata,   // [31:0] capture_time
	input  logic                          s_tuser,   // [0] kind
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [71:0]                   m_tdata,   // [31:0] rev_period_us,
	                                                 // [51:32] rpm_x10,
	                                                 // [67:52] speed_kmh_x100, rest zero
	output logic                          m_tuser,   // [0] event_res
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [wsp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data
);
	import wsp_pkg::*;

	localparam logic [63:0] TMASK64 = (64'd1 << TIME_BITS) - 64'd1;
	localparam logic [31:0] TMASK   = TMASK64[31:0];

	typedef enum logic [2:0] {
		ST_IDLE, ST_TMOD, ST_SMOD, ST_SPAN, ST_RANGE, ST_RPM, ST_KMH, ST_EMIT
	} state_t;

	cfg_t cfg;

	state_t                state_q;
	logic [3:0]            edge_idx_q;
	logic                  have_start_q;
	logic [TIME_BITS-1:0]  rev_start_q;
	logic [10:0]           ms_q;
	logic                  seen_rev_q;
	logic                  stopped_q;

	logic                  div_go_q;
	logic [DIV_W-1:0]      div_num_q;
	logic [DIV_W-1:0]      div_den_q;
	logic                  div_done;
	logic [DIV_W-1:0]      div_quot;
	logic [DIV_W-1:0]      div_rem;

	logic [TIME_BITS-1:0]  t_q;
	logic [32:0]           sum_q;
	logic [31:0]           span_q;
	logic [31:0]           kmh_num_q;
	logic [19:0]           rpm_q;

	logic                  res_ev_q;
	logic [19:0]           res_rpm_q;
	logic [15:0]           res_kmh_q;

	logic                  m_tvalid_q;
	logic [71:0]           m_tdata_q;
	logic                  m_tuser_q;

	logic                  s_acc;
	logic [10:0]           ms_next;
	logic [3:0]            edge_next;
	logic [32:0]           span_red;
	logic [31:0]           circ_x360;
	logic [31:0]           half_span;
	logic                  out_free;
	logic                  in_range;
	logic                  div_launch;

	wsp_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	wsp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go_q),
		.dividend (div_num_q),
		.divisor  (div_den_q),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign s_acc     = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;

	assign ms_next   = (ms_q < MS_MAX) ? ms_q + 11'd1 : ms_q;
	assign edge_next = edge_idx_q + 4'd1;
	// sum < 2 * modulus, so one conditional subtract finishes the wrap
	assign span_red  = (sum_q >= {1'b0, cfg.modulus}) ? sum_q - {1'b0, cfg.modulus} : sum_q;
	assign circ_x360 = {2'b0, cfg.circ_um, 8'b0} + {4'b0, cfg.circ_um, 6'b0}
	                 + {5'b0, cfg.circ_um, 5'b0} + {7'b0, cfg.circ_um, 3'b0};
	assign half_span = {1'b0, span_q[31:1]};
	assign in_range  = !(span_q < cfg.min_per || span_q > cfg.max_per);

	// states that hand an operand pair to the divider
	assign div_launch = ((state_q == ST_IDLE) && s_acc && (s_tuser == KIND_EDGE))
	                 || ((state_q == ST_TMOD) && div_done && have_start_q
	                     && !(edge_next < cfg.ppr))
	                 || ((state_q == ST_RANGE) && in_range)
	                 || ((state_q == ST_RPM) && div_done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			edge_idx_q   <= '0;
			have_start_q <= 1'b0;
			rev_start_q  <= '0;
			ms_q         <= '0;
			seen_rev_q   <= 1'b0;
			stopped_q    <= 1'b1;
			div_go_q     <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			div_go_q <= div_launch;
			if (state_q == ST_EMIT && out_free)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						if (s_tuser == KIND_TICK) begin
							if (seen_rev_q) begin
								ms_q <= ms_next;
								if (ms_next > cfg.timeout_ms && !stopped_q) begin
									stopped_q <= 1'b1;
									res_ev_q  <= EV_STOP;
									span_q    <= '0;
									res_rpm_q <= '0;
									res_kmh_q <= '0;
									state_q   <= ST_EMIT;
								end
							end
						end else begin
							div_num_q <= s_tdata & TMASK;
							div_den_q <= cfg.modulus;
							state_q   <= ST_TMOD;
						end
					end
				end
				ST_TMOD: begin
					if (div_done) begin
						t_q <= div_rem[TIME_BITS-1:0];
						if (!have_start_q) begin
							have_start_q <= 1'b1;
							rev_start_q  <= div_rem[TIME_BITS-1:0];
							edge_idx_q   <= '0;
							state_q      <= ST_IDLE;
						end else if (edge_next < cfg.ppr) begin
							edge_idx_q <= edge_next;
							state_q    <= ST_IDLE;
						end else begin
							// stored start may predate a modulus change
							div_num_q <= DIV_W'(rev_start_q);
							div_den_q <= cfg.modulus;
							state_q   <= ST_SMOD;
						end
					end
				end
				ST_SMOD: begin
					if (div_done) begin
						sum_q   <= 33'(t_q) + {1'b0, cfg.modulus} - {1'b0, div_rem};
						state_q <= ST_SPAN;
					end
				end
				ST_SPAN: begin
					span_q      <= span_red[31:0];
					rev_start_q <= t_q;
					edge_idx_q  <= '0;
					ms_q        <= '0;
					seen_rev_q  <= 1'b1;
					state_q     <= ST_RANGE;
				end
				ST_RANGE: begin
					if (!in_range) begin
						state_q <= ST_IDLE;
					end else begin
						stopped_q <= 1'b0;
						res_ev_q  <= EV_SPEED;
						div_num_q <= RPM_NUM + half_span;
						div_den_q <= span_q;
						kmh_num_q <= circ_x360 + half_span;
						state_q   <= ST_RPM;
					end
				end
				ST_RPM: begin
					if (div_done) begin
						rpm_q     <= (div_quot > 32'(RPM_MAX)) ? RPM_MAX : div_quot[19:0];
						div_num_q <= kmh_num_q;
						div_den_q <= span_q;
						state_q   <= ST_KMH;
					end
				end
				ST_KMH: begin
					if (div_done) begin
						res_rpm_q <= rpm_q;
						res_kmh_q <= (div_quot > 32'(KMH_MAX)) ? KMH_MAX : div_quot[15:0];
						state_q   <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						m_tuser_q  <= res_ev_q;
						m_tdata_q  <= {4'b0, res_kmh_q, res_rpm_q, span_q};
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// ===== hw/rtl/wsp_chk.sv =====
// Port-level checker for the wheel speed tachometer, bound to the top level.
// Depends only on the top level's ports.
module wsp_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata,
	input logic        m_tuser
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// a stopped beat carries an all-zero payload
	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 72'd0)
		else $error("stopped beat with nonzero payload");

	// speed beats keep rpm within its saturation value and pad bits stay clear
	a_rpm_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[51:32] <= 20'd1000000 && m_tdata[71:68] == 4'd0)
		else $error("rpm above saturation or pad bits set");

	// an edge occupies the divider, so the input side closes next cycle
	a_edge_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tuser |=> !s_tready)
		else $error("input ready right after an edge beat");

endmodule

bind wheel_speed_from_pulse_captures wsp_chk u_wsp_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
